// ===== design/qou_pkg.sv =====
// Shared types, constants and helper functions of the quaternion orientation unit.
package qou_pkg;

  localparam int unsigned CompWidth = 32;
  localparam int unsigned FracBits  = 30;
  localparam int unsigned VecFrac   = 16;
  localparam int unsigned ThrWidth  = 30;
  localparam int unsigned ActWidth  = 3;
  localparam int unsigned MulWidth  = 33;
  localparam int unsigned ProdWidth = 66;
  localparam int unsigned VprWidth  = 64;
  localparam int unsigned AccWidth  = 100;
  localparam int unsigned LenWidth  = 33;
  localparam int unsigned RemWidth  = 36;
  localparam int unsigned NumWidth  = 62;
  localparam int unsigned IterWidth = 6;
  localparam int unsigned SqrtSteps = 33;
  localparam int unsigned DivSteps  = 62;

  localparam logic [ThrWidth-1:0]         ThrReset = 30'd1024;
  localparam logic signed [CompWidth-1:0] OneQ     = 32'sh4000_0000;
  localparam logic signed [CompWidth-1:0] CompMax  = 32'sh7fff_ffff;
  localparam logic signed [CompWidth-1:0] CompMin  = 32'sh8000_0000;

  typedef logic signed [CompWidth-1:0] comp_t;

  typedef enum logic [ActWidth-1:0] {
    ACT_LOAD = 3'd0,
    ACT_MUL  = 3'd1,
    ACT_ROT  = 3'd2,
    ACT_INT  = 3'd3,
    ACT_NORM = 3'd4
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_VPROD, ST_MAC, ST_WRITE, ST_SQ, ST_SQRT, ST_CHECK,
    ST_DIV_INIT, ST_DIV, ST_DIV_WRITE, ST_COMMIT
  } state_e;

  typedef enum logic [3:0] {
    DP_NONE, DP_ACCEPT, DP_VPROD, DP_MAC, DP_WRITE, DP_SQ, DP_SQRT, DP_CHECK,
    DP_DIV_INIT, DP_DIV, DP_DIV_WRITE, DP_COMMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] comp;
    logic [1:0] term;
    logic       hi;
    logic       first;
  } dp_cmd_t;

  typedef struct packed {
    logic degen;
  } dp_stat_t;

  typedef struct packed {
    logic [1:0] a_idx;
    logic [1:0] b_idx;
    logic       neg;
  } ham_term_t;

  typedef struct packed {
    comp_t val;
    logic  clip;
  } sat_t;

  // One term of the Hamilton product a * b: component c, term t.
  function automatic ham_term_t ham_term(logic [1:0] c, logic [1:0] t);
    ham_term_t r;
    case ({c, t})
      4'h0: r = '{2'd0, 2'd0, 1'b0};
      4'h1: r = '{2'd1, 2'd1, 1'b1};
      4'h2: r = '{2'd2, 2'd2, 1'b1};
      4'h3: r = '{2'd3, 2'd3, 1'b1};
      4'h4: r = '{2'd0, 2'd1, 1'b0};
      4'h5: r = '{2'd1, 2'd0, 1'b0};
      4'h6: r = '{2'd2, 2'd3, 1'b0};
      4'h7: r = '{2'd3, 2'd2, 1'b1};
      4'h8: r = '{2'd0, 2'd2, 1'b0};
      4'h9: r = '{2'd2, 2'd0, 1'b0};
      4'ha: r = '{2'd3, 2'd1, 1'b0};
      4'hb: r = '{2'd1, 2'd3, 1'b1};
      4'hc: r = '{2'd0, 2'd3, 1'b0};
      4'hd: r = '{2'd3, 2'd0, 1'b0};
      4'he: r = '{2'd1, 2'd2, 1'b0};
      default: r = '{2'd2, 2'd1, 1'b1};
    endcase
    return r;
  endfunction

  // Clamp a wide signed value to one component.
  function automatic sat_t sat_comp(logic signed [AccWidth-1:0] v);
    sat_t r;
    logic [AccWidth-CompWidth:0] top;
    top = v[AccWidth-1:CompWidth-1];
    if (top == '0 || top == '1) begin
      r.val  = v[CompWidth-1:0];
      r.clip = 1'b0;
    end else begin
      r.val  = v[AccWidth-1] ? CompMin : CompMax;
      r.clip = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== design/qou_channels.sv =====
// Handshake channel interfaces of the quaternion orientation unit.
interface qou_in_if;
  logic                               valid;
  logic                               ready;
  logic [qou_pkg::ActWidth-1:0]       action;
  logic signed [qou_pkg::CompWidth-1:0] vec_x;
  logic signed [qou_pkg::CompWidth-1:0] vec_y;
  logic signed [qou_pkg::CompWidth-1:0] vec_z;
  logic signed [qou_pkg::CompWidth-1:0] step_scale;
  logic signed [qou_pkg::CompWidth-1:0] operand_w;
  logic signed [qou_pkg::CompWidth-1:0] operand_x;
  logic signed [qou_pkg::CompWidth-1:0] operand_y;
  logic signed [qou_pkg::CompWidth-1:0] operand_z;
  modport source (output valid, action, vec_x, vec_y, vec_z, step_scale,
                  operand_w, operand_x, operand_y, operand_z, input ready);
  modport sink (input valid, action, vec_x, vec_y, vec_z, step_scale,
                operand_w, operand_x, operand_y, operand_z, output ready);
endinterface

interface qou_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qou_pkg::CompWidth-1:0] result_w;
  logic signed [qou_pkg::CompWidth-1:0] result_x;
  logic signed [qou_pkg::CompWidth-1:0] result_y;
  logic signed [qou_pkg::CompWidth-1:0] result_z;
  logic                                 degenerate;
  logic                                 saturated;
  modport source (output valid, result_w, result_x, result_y, result_z, degenerate,
                  saturated, input ready);
  modport sink (input valid, result_w, result_x, result_y, result_z, degenerate,
                saturated, output ready);
endinterface

interface qou_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [qou_pkg::ThrWidth-1:0] zero_length_threshold;
  modport source (output valid, zero_length_threshold, input ready);
  modport sink (input valid, zero_length_threshold, output ready);
endinterface

// ===== design/qou_datapath.sv =====
// Datapath of the quaternion orientation unit: shared multiplier, accumulator, root and divider.
module qou_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  qou_pkg::dp_cmd_t                cmd_i,
  output qou_pkg::dp_stat_t               stat_o,
  input  logic [qou_pkg::ActWidth-1:0]    action_i,
  input  qou_pkg::comp_t                  vec_x_i,
  input  qou_pkg::comp_t                  vec_y_i,
  input  qou_pkg::comp_t                  vec_z_i,
  input  qou_pkg::comp_t                  step_scale_i,
  input  qou_pkg::comp_t                  operand_w_i,
  input  qou_pkg::comp_t                  operand_x_i,
  input  qou_pkg::comp_t                  operand_y_i,
  input  qou_pkg::comp_t                  operand_z_i,
  input  logic                            cfg_we_i,
  input  logic [qou_pkg::ThrWidth-1:0]    cfg_thr_i,
  output qou_pkg::comp_t                  result_w_o,
  output qou_pkg::comp_t                  result_x_o,
  output qou_pkg::comp_t                  result_y_o,
  output qou_pkg::comp_t                  result_z_o,
  output logic                            degenerate_o,
  output logic                            saturated_o
);

  localparam int unsigned AW = qou_pkg::AccWidth;
  localparam logic signed [AW-1:0] RndMul = AW'(1) << (qou_pkg::FracBits - 1);
  localparam logic signed [AW-1:0] RndRot = AW'(1) << (qou_pkg::VecFrac - 1);
  localparam logic signed [AW-1:0] RndInt = AW'(1) << (2 * qou_pkg::VecFrac);

  qou_pkg::comp_t q_q [4];
  qou_pkg::comp_t nq_q [4];
  qou_pkg::comp_t bop_q [4];
  qou_pkg::comp_t res_q [4];
  qou_pkg::comp_t scale_q;
  logic signed [qou_pkg::VprWidth-1:0] bv_q [4];
  logic [qou_pkg::ActWidth-1:0] act_q;
  logic [qou_pkg::ThrWidth-1:0] thr_q;
  logic signed [AW-1:0] acc_q;
  logic [qou_pkg::LenWidth-1:0] root_q;
  logic [qou_pkg::RemWidth-1:0] rem_q;
  logic [qou_pkg::NumWidth-1:0] num_q, quo_q;
  logic neg_q, degen_q, sat_q, res_degen_q, res_sat_q;

  qou_pkg::ham_term_t ht;
  logic signed [qou_pkg::MulWidth-1:0] ma, mb;
  logic signed [qou_pkg::ProdWidth-1:0] prod;
  logic signed [AW-1:0] term_ext, term_sh, acc_base, mac_acc;
  logic signed [AW-1:0] rnd_sum, shifted, wr_sum;
  qou_pkg::sat_t wr, dv;
  logic [qou_pkg::RemWidth-1:0] sq_rem_base, sq_rem_sh, sq_trial, sq_rem_d;
  logic [qou_pkg::LenWidth-1:0] sq_root_base;
  logic sq_ge, degen;
  logic [qou_pkg::CompWidth-1:0] mag;
  logic [qou_pkg::RemWidth-1:0] dv_rem_sh;
  logic dv_ge;

  assign ht   = qou_pkg::ham_term(cmd_i.comp, cmd_i.term);
  assign prod = ma * mb;

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      qou_pkg::DP_VPROD: begin
        ma = qou_pkg::MulWidth'(bop_q[cmd_i.comp]);
        mb = qou_pkg::MulWidth'(scale_q);
      end
      qou_pkg::DP_MAC: begin
        if (act_q == qou_pkg::ACT_INT) begin
          ma = cmd_i.hi ? qou_pkg::MulWidth'($signed(bv_q[ht.a_idx][63:32]))
                        : $signed({1'b0, bv_q[ht.a_idx][31:0]});
          mb = qou_pkg::MulWidth'(q_q[ht.b_idx]);
        end else begin
          ma = qou_pkg::MulWidth'(q_q[ht.a_idx]);
          mb = qou_pkg::MulWidth'(bop_q[ht.b_idx]);
        end
      end
      qou_pkg::DP_SQ: begin
        ma = qou_pkg::MulWidth'(q_q[cmd_i.comp]);
        mb = qou_pkg::MulWidth'(q_q[cmd_i.comp]);
      end
      default: ;
    endcase
  end

  // Multiply-accumulate; the high half of a 64-bit operand is weighted by 2^32.
  always_comb begin
    term_ext = AW'(prod);
    term_sh  = cmd_i.hi ? (term_ext <<< 32) : term_ext;
    acc_base = cmd_i.first ? '0 : acc_q;
    if (cmd_i.op == qou_pkg::DP_MAC && ht.neg) begin
      mac_acc = acc_base - term_sh;
    end else begin
      mac_acc = acc_base + term_sh;
    end
  end

  // Round to nearest (ties up), rescale, add q for integrate, then clamp.
  always_comb begin
    case (act_q)
      qou_pkg::ACT_MUL: begin
        rnd_sum = acc_q + RndMul;
        shifted = rnd_sum >>> qou_pkg::FracBits;
      end
      qou_pkg::ACT_ROT: begin
        rnd_sum = acc_q + RndRot;
        shifted = rnd_sum >>> qou_pkg::VecFrac;
      end
      default: begin
        rnd_sum = acc_q + RndInt;
        shifted = rnd_sum >>> (2 * qou_pkg::VecFrac + 1);
      end
    endcase
    wr_sum = shifted + ((act_q == qou_pkg::ACT_INT) ? AW'(q_q[cmd_i.comp]) : '0);
    wr     = qou_pkg::sat_comp(wr_sum);
  end

  // Restoring square root, two radicand bits per step.
  always_comb begin
    sq_rem_base  = cmd_i.first ? '0 : rem_q;
    sq_root_base = cmd_i.first ? '0 : root_q;
    sq_rem_sh    = {sq_rem_base[qou_pkg::RemWidth-3:0], acc_q[65:64]};
    sq_trial     = {1'b0, sq_root_base, 2'b01};
    sq_ge        = (sq_rem_sh >= sq_trial);
    sq_rem_d     = sq_ge ? (sq_rem_sh - sq_trial) : sq_rem_sh;
  end

  assign degen = (root_q == '0) || (root_q < qou_pkg::LenWidth'(thr_q));
  assign stat_o.degen = degen;

  // Restoring division of the scaled magnitude by the length.
  assign mag       = q_q[cmd_i.comp][qou_pkg::CompWidth-1] ? (-q_q[cmd_i.comp])
                                                            : q_q[cmd_i.comp];
  assign dv_rem_sh = {rem_q[qou_pkg::RemWidth-2:0], num_q[qou_pkg::NumWidth-1]};
  assign dv_ge     = (dv_rem_sh >= qou_pkg::RemWidth'(root_q));

  always_comb begin
    dv.clip = 1'b0;
    if (!neg_q) begin
      if (quo_q[qou_pkg::NumWidth-1:31] != '0) begin
        dv.val  = qou_pkg::CompMax;
        dv.clip = 1'b1;
      end else begin
        dv.val = quo_q[31:0];
      end
    end else begin
      if (quo_q[qou_pkg::NumWidth-1:32] != '0 || (quo_q[31] && quo_q[30:0] != '0)) begin
        dv.val  = qou_pkg::CompMin;
        dv.clip = 1'b1;
      end else begin
        dv.val = -quo_q[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q[0] <= qou_pkg::OneQ;
      q_q[1] <= '0;
      q_q[2] <= '0;
      q_q[3] <= '0;
      thr_q  <= qou_pkg::ThrReset;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_thr_i;
      end
      if (cmd_i.op == qou_pkg::DP_COMMIT) begin
        q_q <= nq_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      qou_pkg::DP_ACCEPT: begin
        act_q   <= action_i;
        scale_q <= step_scale_i;
        bv_q[0] <= '0;
        sat_q   <= 1'b0;
        degen_q <= 1'b0;
        if (action_i == qou_pkg::ACT_ROT || action_i == qou_pkg::ACT_INT) begin
          bop_q[0] <= '0;
          bop_q[1] <= vec_x_i;
          bop_q[2] <= vec_y_i;
          bop_q[3] <= vec_z_i;
        end else begin
          bop_q[0] <= operand_w_i;
          bop_q[1] <= operand_x_i;
          bop_q[2] <= operand_y_i;
          bop_q[3] <= operand_z_i;
        end
        if (action_i == qou_pkg::ACT_LOAD) begin
          nq_q[0] <= operand_w_i;
          nq_q[1] <= operand_x_i;
          nq_q[2] <= operand_y_i;
          nq_q[3] <= operand_z_i;
        end else begin
          nq_q <= q_q;
        end
      end
      qou_pkg::DP_VPROD: bv_q[cmd_i.comp] <= prod[qou_pkg::VprWidth-1:0];
      qou_pkg::DP_MAC: acc_q <= mac_acc;
      qou_pkg::DP_WRITE: begin
        nq_q[cmd_i.comp] <= wr.val;
        sat_q            <= sat_q | wr.clip;
      end
      qou_pkg::DP_SQ: acc_q <= mac_acc;
      qou_pkg::DP_SQRT: begin
        rem_q  <= sq_rem_d;
        root_q <= {sq_root_base[qou_pkg::LenWidth-2:0], sq_ge};
        acc_q  <= acc_q <<< 2;
      end
      qou_pkg::DP_CHECK: begin
        if (degen) begin
          nq_q[0] <= qou_pkg::OneQ;
          nq_q[1] <= '0;
          nq_q[2] <= '0;
          nq_q[3] <= '0;
          degen_q <= 1'b1;
        end
      end
      qou_pkg::DP_DIV_INIT: begin
        num_q <= {mag, {qou_pkg::FracBits{1'b0}}} + qou_pkg::NumWidth'(root_q[qou_pkg::LenWidth-1:1]);
        neg_q <= q_q[cmd_i.comp][qou_pkg::CompWidth-1];
        rem_q <= '0;
        quo_q <= '0;
      end
      qou_pkg::DP_DIV: begin
        rem_q <= dv_ge ? (dv_rem_sh - qou_pkg::RemWidth'(root_q)) : dv_rem_sh;
        quo_q <= {quo_q[qou_pkg::NumWidth-2:0], dv_ge};
        num_q <= num_q << 1;
      end
      qou_pkg::DP_DIV_WRITE: begin
        nq_q[cmd_i.comp] <= dv.val;
        sat_q            <= sat_q | dv.clip;
      end
      qou_pkg::DP_COMMIT: begin
        res_q       <= nq_q;
        res_degen_q <= degen_q;
        res_sat_q   <= sat_q;
      end
      default: ;
    endcase
  end

  assign result_w_o   = res_q[0];
  assign result_x_o   = res_q[1];
  assign result_y_o   = res_q[2];
  assign result_z_o   = res_q[3];
  assign degenerate_o = res_degen_q;
  assign saturated_o  = res_sat_q;

endmodule

// ===== design/qou_controller.sv =====
// Sequencing state machine of the quaternion orientation unit.
module qou_controller (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [qou_pkg::ActWidth-1:0] action_i,
  output logic                         in_ready_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  input  qou_pkg::dp_stat_t            stat_i,
  output qou_pkg::dp_cmd_t             cmd_o
);

  qou_pkg::state_e state_q, state_d;
  logic [1:0] comp_q, comp_d, term_q, term_d;
  logic part_q, part_d;
  logic [qou_pkg::IterWidth-1:0] iter_q, iter_d;
  logic [qou_pkg::ActWidth-1:0] action_q, action_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d  = state_q;
    comp_d   = comp_q;
    term_d   = term_q;
    part_d   = part_q;
    iter_d   = iter_q;
    action_d = action_q;
    case (state_q)
      qou_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          action_d = action_i;
          comp_d   = '0;
          term_d   = '0;
          part_d   = 1'b0;
          case (action_i)
            qou_pkg::ACT_MUL, qou_pkg::ACT_ROT: state_d = qou_pkg::ST_MAC;
            qou_pkg::ACT_INT: begin
              state_d = qou_pkg::ST_VPROD;
              comp_d  = 2'd1;
            end
            qou_pkg::ACT_NORM: state_d = qou_pkg::ST_SQ;
            default: state_d = qou_pkg::ST_COMMIT;
          endcase
        end
      end
      qou_pkg::ST_VPROD: begin
        if (comp_q == 2'd3) begin
          comp_d  = '0;
          state_d = qou_pkg::ST_MAC;
        end else begin
          comp_d = comp_q + 2'd1;
        end
      end
      qou_pkg::ST_MAC: begin
        if (action_q == qou_pkg::ACT_INT) begin
          part_d = !part_q;
          if (part_q) begin
            term_d = term_q + 2'd1;
          end
        end else begin
          term_d = term_q + 2'd1;
        end
        if (term_q == 2'd3 && (action_q != qou_pkg::ACT_INT || part_q)) begin
          state_d = qou_pkg::ST_WRITE;
        end
      end
      qou_pkg::ST_WRITE: begin
        if (comp_q == 2'd3) begin
          state_d = qou_pkg::ST_COMMIT;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = qou_pkg::ST_MAC;
        end
      end
      qou_pkg::ST_SQ: begin
        if (comp_q == 2'd3) begin
          iter_d  = '0;
          state_d = qou_pkg::ST_SQRT;
        end else begin
          comp_d = comp_q + 2'd1;
        end
      end
      qou_pkg::ST_SQRT: begin
        if (iter_q == qou_pkg::IterWidth'(qou_pkg::SqrtSteps - 1)) begin
          state_d = qou_pkg::ST_CHECK;
        end else begin
          iter_d = iter_q + 1'b1;
        end
      end
      qou_pkg::ST_CHECK: begin
        comp_d  = '0;
        state_d = stat_i.degen ? qou_pkg::ST_COMMIT : qou_pkg::ST_DIV_INIT;
      end
      qou_pkg::ST_DIV_INIT: begin
        iter_d  = '0;
        state_d = qou_pkg::ST_DIV;
      end
      qou_pkg::ST_DIV: begin
        if (iter_q == qou_pkg::IterWidth'(qou_pkg::DivSteps - 1)) begin
          state_d = qou_pkg::ST_DIV_WRITE;
        end else begin
          iter_d = iter_q + 1'b1;
        end
      end
      qou_pkg::ST_DIV_WRITE: begin
        if (comp_q == 2'd3) begin
          state_d = qou_pkg::ST_COMMIT;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = qou_pkg::ST_DIV_INIT;
        end
      end
      qou_pkg::ST_COMMIT: begin
        if (slot_free) begin
          state_d = qou_pkg::ST_IDLE;
        end
      end
      default: state_d = qou_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '{qou_pkg::DP_NONE, comp_q, term_q, part_q, 1'b0};
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      qou_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = qou_pkg::DP_ACCEPT;
        end
      end
      qou_pkg::ST_VPROD: cmd_o.op = qou_pkg::DP_VPROD;
      qou_pkg::ST_MAC: begin
        cmd_o.op    = qou_pkg::DP_MAC;
        cmd_o.first = (term_q == 2'd0) && !part_q;
      end
      qou_pkg::ST_WRITE: cmd_o.op = qou_pkg::DP_WRITE;
      qou_pkg::ST_SQ: begin
        cmd_o.op    = qou_pkg::DP_SQ;
        cmd_o.first = (comp_q == 2'd0);
      end
      qou_pkg::ST_SQRT: begin
        cmd_o.op    = qou_pkg::DP_SQRT;
        cmd_o.first = (iter_q == '0);
      end
      qou_pkg::ST_CHECK: cmd_o.op = qou_pkg::DP_CHECK;
      qou_pkg::ST_DIV_INIT: cmd_o.op = qou_pkg::DP_DIV_INIT;
      qou_pkg::ST_DIV: cmd_o.op = qou_pkg::DP_DIV;
      qou_pkg::ST_DIV_WRITE: cmd_o.op = qou_pkg::DP_DIV_WRITE;
      qou_pkg::ST_COMMIT: begin
        if (slot_free) begin
          cmd_o.op    = qou_pkg::DP_COMMIT;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qou_pkg::ST_IDLE;
      comp_q      <= '0;
      term_q      <= '0;
      part_q      <= 1'b0;
      iter_q      <= '0;
      action_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      comp_q      <= comp_d;
      term_q      <= term_d;
      part_q      <= part_d;
      iter_q      <= iter_d;
      action_q    <= action_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // The length check only follows a normalize request.
  a_check_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == qou_pkg::ST_CHECK |-> action_q == qou_pkg::ACT_NORM)
    else $error("length check outside normalize");

  // Only integrate splits each term into two partial products.
  a_part_int: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qou_pkg::ST_MAC && action_q != qou_pkg::ACT_INT) |-> !part_q)
    else $error("partial product step outside integrate");

  // A finished result waits while the previous one is still held.
  a_commit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qou_pkg::ST_COMMIT && out_valid_q && !out_ready_i)
      |=> state_q == qou_pkg::ST_COMMIT)
    else $error("result committed over a pending beat");

  // A normalize beat starts with the sum of squares.
  a_norm_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && action_i == qou_pkg::ACT_NORM)
      |=> state_q == qou_pkg::ST_SQ)
    else $error("normalize did not start with the sum of squares");

endmodule

// ===== design/quaternion_orientation_unit.sv =====
// Top level of the quaternion orientation unit: controller, datapath and channels.
//
// The unit holds one orientation quaternion (Q2.30 components, reset to the
// identity) and applies one action per input beat: load, Hamilton multiply,
// rotate by a Q16.16 vector, integrate a scaled vector, or normalize. Each
// beat returns exactly one output beat with the updated quaternion and the
// degenerate and saturated flags. One item is worked on at a time, and all
// arithmetic runs through a single 33 by 33 bit multiplier with a 100-bit
// accumulator. Load and unused action codes go straight to the commit,
// multiply and rotate take four products and a write per component, then the
// commit, integrate takes three vector-scale products, then eight partial
// products and a write per component, then the commit, and normalize takes
// the sum of four squares, a 33-step square root (two bits per step), one
// length check, and for each of the four components one setup step, a 62-step
// restoring division and one write, then the commit.
// A new input beat is taken once the previous result sits in the output
// register, so a pending result only stalls the unit when the next one is
// ready to leave. The threshold register is written through its own channel,
// which is always ready; write it only while the unit is idle.
module quaternion_orientation_unit (
  input logic       clk_i,
  input logic       rst_ni,
  qou_in_if.sink    in_ch_i,
  qou_out_if.source out_ch_o,
  qou_cfg_if.sink   cfg_ch_i
);

  qou_pkg::dp_cmd_t  cmd;
  qou_pkg::dp_stat_t stat;

  assign cfg_ch_i.ready = 1'b1;

  qou_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch_i.valid),
    .action_i    (in_ch_i.action),
    .in_ready_o  (in_ch_i.ready),
    .out_ready_i (out_ch_o.ready),
    .out_valid_o (out_ch_o.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  qou_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .action_i     (in_ch_i.action),
    .vec_x_i      (in_ch_i.vec_x),
    .vec_y_i      (in_ch_i.vec_y),
    .vec_z_i      (in_ch_i.vec_z),
    .step_scale_i (in_ch_i.step_scale),
    .operand_w_i  (in_ch_i.operand_w),
    .operand_x_i  (in_ch_i.operand_x),
    .operand_y_i  (in_ch_i.operand_y),
    .operand_z_i  (in_ch_i.operand_z),
    .cfg_we_i     (cfg_ch_i.valid),
    .cfg_thr_i    (cfg_ch_i.zero_length_threshold),
    .result_w_o   (out_ch_o.result_w),
    .result_x_o   (out_ch_o.result_x),
    .result_y_o   (out_ch_o.result_y),
    .result_z_o   (out_ch_o.result_z),
    .degenerate_o (out_ch_o.degenerate),
    .saturated_o  (out_ch_o.saturated)
  );

endmodule
